FILE: rtl/core/pjd_pkg.sv
package pjd_pkg;

    localparam int QUEUE_DEPTH = 64;
    localparam int MAX_CPUS    = 64;
    localparam int MAX_OUT     = 64;

    localparam int QIW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CIW      = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int QCW      = $clog2(QUEUE_DEPTH + 1);
    localparam int CCW      = $clog2(MAX_CPUS + 1);
    localparam int NW       = $clog2(MAX_OUT + 1);
    localparam int SCAN_LEN = (QUEUE_DEPTH > MAX_CPUS) ? QUEUE_DEPTH : MAX_CPUS;
    localparam int SCW      = $clog2(SCAN_LEN + 1);

    localparam logic [1:0] ST_STORED     = 2'd0;
    localparam logic [1:0] ST_DROPPED    = 2'd1;
    localparam logic [1:0] ST_DISPATCHED = 2'd2;
    localparam logic [1:0] ST_NONE       = 2'd3;

    typedef struct packed {
        logic [15:0] importance;
        logic [31:0] arrival;
        logic [31:0] length;
        logic [31:0] ident;
        logic [31:0] origin;
        logic [31:0] instruction;
    } job_t;

    typedef struct packed {
        logic           has_best;
        job_t           best;
        logic [15:0]    age;
        logic [QIW-1:0] best_idx;
        logic           has_free;
        logic [QIW-1:0] free_idx;
    } job_carry_t;

    typedef struct packed {
        logic           en;
        logic [QIW-1:0] idx;
        job_t           job;
        logic [15:0]    order;
    } job_wr_t;

    typedef struct packed {
        logic           en;
        logic [QIW-1:0] idx;
    } job_clr_t;

    typedef struct packed {
        logic [CCW-1:0] free_cnt;
        logic           has_free;
        logic [CIW-1:0] free_idx;
    } cpu_carry_t;

    typedef struct packed {
        logic        en;
        logic [31:0] now;
    } cpu_exp_t;

    typedef struct packed {
        logic           en;
        logic [CIW-1:0] idx;
        logic [32:0]    release_at;
    } cpu_alloc_t;

    // a leaves before b
    function automatic logic job_before(job_t a, logic [15:0] age_a,
                                        job_t b, logic [15:0] age_b);
        logic r;
        if (a.importance != b.importance)
            r = a.importance > b.importance;
        else if (a.arrival != b.arrival)
            r = a.arrival < b.arrival;
        else if (a.length != b.length)
            r = a.length < b.length;
        else
            r = age_a > age_b;
        return r;
    endfunction

endpackage

FILE: rtl/core/pjd_job_cell.sv
module pjd_job_cell import pjd_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [QIW-1:0] cell_idx,
    input  job_wr_t        wr,
    input  job_clr_t       clr,
    input  logic [15:0]    insert_count,
    input  job_carry_t     carry_in,
    output job_carry_t     carry_out
);

    logic       valid_reg;
    job_t       job_reg;
    logic [15:0] order_reg;
    job_carry_t carry_reg;
    job_carry_t carry_next;
    logic [15:0] age;

    always_comb begin
        age        = insert_count - order_reg;
        carry_next = carry_in;
        if (!valid_reg && !carry_in.has_free) begin
            carry_next.has_free = 1'b1;
            carry_next.free_idx = cell_idx;
        end
        if (valid_reg && (!carry_in.has_best ||
                job_before(job_reg, age, carry_in.best, carry_in.age))) begin
            carry_next.has_best = 1'b1;
            carry_next.best     = job_reg;
            carry_next.age      = age;
            carry_next.best_idx = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            carry_reg <= '0;
        end else begin
            carry_reg <= carry_next;
            if (wr.en && wr.idx == cell_idx) begin
                valid_reg <= 1'b1;
            end else if (clr.en && clr.idx == cell_idx) begin
                valid_reg <= 1'b0;
            end
        end
        if (wr.en && wr.idx == cell_idx) begin
            job_reg   <= wr.job;
            order_reg <= wr.order;
        end
    end

    assign carry_out = carry_reg;

endmodule

FILE: rtl/core/pjd_cpu_cell.sv
module pjd_cpu_cell import pjd_pkg::*; (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [CIW-1:0] cell_idx,
    input  logic [CCW-1:0] pool,
    input  cpu_exp_t       expire,
    input  cpu_alloc_t     alloc,
    input  cpu_carry_t     carry_in,
    output cpu_carry_t     carry_out
);

    logic        busy_reg;
    logic [32:0] release_reg;
    cpu_carry_t  carry_reg;
    cpu_carry_t  carry_next;
    logic        is_free;

    always_comb begin
        is_free    = (CCW'(cell_idx) < pool) && !busy_reg;
        carry_next = carry_in;
        carry_next.free_cnt = carry_in.free_cnt + CCW'(is_free);
        if (is_free && !carry_in.has_free) begin
            carry_next.has_free = 1'b1;
            carry_next.free_idx = cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            carry_reg <= '0;
        end else begin
            carry_reg <= carry_next;
            if (expire.en && busy_reg && release_reg <= {1'b0, expire.now}) begin
                busy_reg <= 1'b0;
            end else if (alloc.en && alloc.idx == cell_idx) begin
                busy_reg <= 1'b1;
            end
        end
        if (alloc.en && alloc.idx == cell_idx) begin
            release_reg <= alloc.release_at;
        end
    end

    assign carry_out = carry_reg;

endmodule

FILE: rtl/core/priority_job_dispatcher_top.sv
// Priority job dispatcher with a CPU pool.
// Input stream: one beat per command. s_tuser selects add (0) or assign (1).
// Output stream: one beat per result, m_tuser is the status, m_tlast marks
// the final beat of a command. cfg_wr_en/cfg_wr_data load cpu_count.
// Jobs live in a row of job cells, CPUs in a row of CPU cells; a candidate
// (best job, first free slot, free CPU count, first free CPU) ripples one
// cell per cycle, so every decision waits until it has crossed SCAN_LEN
// cells, SCAN_LEN being the longer of the two rows (64 here).
// Add: its single result beat, stored or dropped, comes once the scan is done.
// Assign: an expiry step, then a full scan before the first beat and a
// fresh scan, after each beat is taken, before the next; a single beat if
// nothing is dispatched.
// One command is in flight at a time; s_tready rises the cycle after its last
// beat has been taken. A stalled m_tready holds the beat and the whole block.
// Reset empties the store, frees every CPU and clears cpu_count; no
// clearing pass is needed.
module priority_job_dispatcher_top import pjd_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [6:0]   cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // timestamp, job_id, origin_tag, instruction_tag, importance, run_length,
    // request_count
    input  logic [191:0] s_tdata,
    // mode
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_time, out_id, out_origin, out_instruction, out_importance, out_length
    output logic [175:0] m_tdata,
    // status
    output logic [1:0]   m_tuser,
    output logic         m_tlast
);

    typedef enum logic [1:0] {S_IDLE, S_EXPIRE, S_SCAN, S_OUT} state_t;

    state_t         state_reg;
    logic [6:0]     cpu_count_reg;
    logic           mode_reg;
    logic [31:0]    ts_reg;
    logic [15:0]    req_reg;
    job_t           in_job_reg;
    logic [15:0]    insert_cnt_reg;
    logic [QCW-1:0] waiting_reg;
    logic [SCW-1:0] scan_cnt_reg;
    logic [NW-1:0]  k_reg;
    logic [NW-1:0]  n_reg;
    job_wr_t        wr_reg;
    job_clr_t       clr_reg;
    cpu_exp_t       exp_reg;
    cpu_alloc_t     alloc_reg;
    job_t           out_job_reg;
    logic [1:0]     out_status_reg;
    logic           out_last_reg;
    logic           m_valid_reg;

    job_carry_t     jc [QUEUE_DEPTH+1];
    cpu_carry_t     cc [MAX_CPUS+1];
    logic [CCW-1:0] pool;
    logic [NW-1:0]  n_calc;
    logic [NW-1:0]  n_eff;

    assign jc[0] = '0;
    assign cc[0] = '0;

    always_comb begin
        int cnt;
        int nc;
        cnt  = int'(cpu_count_reg);
        pool = CCW'((cnt > MAX_CPUS) ? MAX_CPUS : cnt);
        nc   = int'(cc[MAX_CPUS].free_cnt);
        if (int'(waiting_reg) < nc) nc = int'(waiting_reg);
        if (int'(req_reg) < nc) nc = int'(req_reg);
        if (MAX_OUT < nc) nc = MAX_OUT;
        n_calc = NW'(nc);
        n_eff  = (k_reg == '0) ? n_calc : n_reg;
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_job
        pjd_job_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .cell_idx     (QIW'(i)),
            .wr           (wr_reg),
            .clr          (clr_reg),
            .insert_count (insert_cnt_reg),
            .carry_in     (jc[i]),
            .carry_out    (jc[i+1])
        );
    end

    for (genvar i = 0; i < MAX_CPUS; i++) begin : g_cpu
        pjd_cpu_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (CIW'(i)),
            .pool      (pool),
            .expire    (exp_reg),
            .alloc     (alloc_reg),
            .carry_in  (cc[i]),
            .carry_out (cc[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            cpu_count_reg  <= '0;
            insert_cnt_reg <= '0;
            waiting_reg    <= '0;
            scan_cnt_reg   <= '0;
            k_reg          <= '0;
            wr_reg         <= '0;
            clr_reg        <= '0;
            exp_reg        <= '0;
            alloc_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cpu_count_reg <= cfg_wr_data;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        mode_reg   <= s_tuser;
                        ts_reg     <= s_tdata[31:0];
                        in_job_reg <= '{importance: s_tdata[143:128],
                                        arrival: s_tdata[31:0],
                                        length: s_tdata[175:144],
                                        ident: s_tdata[63:32],
                                        origin: s_tdata[95:64],
                                        instruction: s_tdata[127:96]};
                        req_reg      <= s_tdata[191:176];
                        k_reg        <= '0;
                        scan_cnt_reg <= '0;
                        if (s_tuser) begin
                            exp_reg   <= '{en: 1'b1, now: s_tdata[31:0]};
                            state_reg <= S_EXPIRE;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_EXPIRE: begin
                    exp_reg.en <= 1'b0;
                    state_reg  <= S_SCAN;
                end
                S_SCAN: begin
                    if (scan_cnt_reg == SCW'(SCAN_LEN)) begin
                        scan_cnt_reg <= '0;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= S_OUT;
                        if (!mode_reg) begin
                            out_job_reg  <= '0;
                            out_last_reg <= 1'b1;
                            if (jc[QUEUE_DEPTH].has_free) begin
                                wr_reg         <= '{en: 1'b1,
                                                    idx: jc[QUEUE_DEPTH].free_idx,
                                                    job: in_job_reg,
                                                    order: insert_cnt_reg};
                                insert_cnt_reg <= insert_cnt_reg + 1'b1;
                                waiting_reg    <= waiting_reg + 1'b1;
                                out_status_reg <= ST_STORED;
                            end else begin
                                out_status_reg <= ST_DROPPED;
                            end
                        end else if (n_eff == '0) begin
                            out_job_reg    <= '0;
                            out_last_reg   <= 1'b1;
                            out_status_reg <= ST_NONE;
                        end else begin
                            if (k_reg == '0) n_reg <= n_calc;
                            clr_reg     <= '{en: 1'b1, idx: jc[QUEUE_DEPTH].best_idx};
                            waiting_reg <= waiting_reg - 1'b1;
                            if (jc[QUEUE_DEPTH].best.length != '0) begin
                                alloc_reg <= '{en: 1'b1,
                                               idx: cc[MAX_CPUS].free_idx,
                                               release_at: {1'b0, ts_reg} +
                                                   {1'b0, jc[QUEUE_DEPTH].best.length}};
                            end
                            out_job_reg    <= jc[QUEUE_DEPTH].best;
                            out_status_reg <= ST_DISPATCHED;
                            out_last_reg   <= (k_reg == n_eff - 1'b1);
                        end
                    end else begin
                        scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    end
                end
                S_OUT: begin
                    wr_reg.en    <= 1'b0;
                    clr_reg.en   <= 1'b0;
                    alloc_reg.en <= 1'b0;
                    if (m_tready) begin
                        m_valid_reg <= 1'b0;
                        if (out_status_reg == ST_DISPATCHED && !out_last_reg) begin
                            k_reg     <= k_reg + 1'b1;
                            state_reg <= S_SCAN;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_job_reg.length, out_job_reg.importance,
                       out_job_reg.instruction, out_job_reg.origin,
                       out_job_reg.ident, out_job_reg.arrival};

endmodule

FILE: rtl/core/pjd_checker.sv
module pjd_checker import pjd_pkg::*; (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input taken while a result is pending");

    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !m_tvalid)
        else $error("result too early after input beat");

    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_STORED || m_tuser == ST_DROPPED ||
                     m_tuser == ST_NONE) |-> m_tlast)
        else $error("single result without tlast");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind priority_job_dispatcher_top pjd_checker u_pjd_checker (.*);
